// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the glyph renderer RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hdl/tgr_pkg.sv =====
// Package for the text glyph renderer: word types, command and kind codes,
// register indexes and fixed constants. No dependencies.
`default_nettype none

package tgr_pkg;

  localparam int PIXEL_W   = 16;
  localparam int ROW_SLOTS = 16;
  localparam int ROW_W     = PIXEL_W * ROW_SLOTS;

  localparam logic CMD_PRINT = 1'b0;
  localparam logic CMD_LOAD  = 1'b1;

  localparam logic KIND_WINDOW = 1'b0;
  localparam logic KIND_ROW    = 1'b1;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_COLOR     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CELL_WIDTH     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CELL_HEIGHT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_INDENT_COLUMN  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PANEL_X_OFFSET = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_PANEL_Y_OFFSET = 3'd7;

  localparam logic [15:0] TEXT_COLOR_RESET    = 16'hFFFF;
  localparam logic [15:0] BACKGROUND_RESET    = 16'h0000;
  localparam logic [4:0]  CELL_WIDTH_RESET    = 5'd12;
  localparam logic [5:0]  CELL_HEIGHT_RESET   = 6'd16;
  localparam logic [9:0]  INDENT_RESET        = 10'd0;
  localparam logic [9:0]  SCREEN_WIDTH_RESET  = 10'd320;
  localparam logic [7:0]  PANEL_X_RESET       = 8'd40;
  localparam logic [7:0]  PANEL_Y_RESET       = 8'd53;

  localparam logic [7:0] FIRST_PRINTABLE = 8'd33;
  localparam logic [7:0] LAST_PRINTABLE  = 8'd127;
  localparam logic [7:0] CHAR_NEWLINE    = 8'd10;
  localparam logic [7:0] CHAR_RETURN     = 8'd13;

  localparam logic [4:0] WIDTH_MIN = 5'd1;
  localparam logic [4:0] WIDTH_MAX = 5'd16;
  localparam logic [9:0] Y_LIMIT   = 10'd1023;

  typedef struct packed {
    logic        command;
    logic [7:0]  char_code;
    logic [6:0]  load_glyph;
    logic [3:0]  load_row;
    logic [15:0] load_bits;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [10:0] x_start;
    logic [10:0] x_end;
    logic [10:0] y_start;
    logic [10:0] y_end;
    logic [63:0] pixels_a;
    logic [63:0] pixels_b;
    logic [63:0] pixels_c;
    logic [63:0] pixels_d;
    logic [4:0]  row_pixels;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/tgr_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module tgr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/tgr_row_unit.sv =====
// Pixel row expander: turns one glyph row bitmap into sixteen RGB565 pixels.
// Depends on tgr_pkg.
`default_nettype none

module tgr_row_unit #(
  parameter int FONT_COLUMNS = 12
) (
  input  logic [15:0]              bits,
  input  logic [15:0]              text_color,
  input  logic [15:0]              background_color,
  input  logic [4:0]               width,
  output logic [tgr_pkg::ROW_W-1:0] pixels
);

  // Columns are tested MSB first; columns past the cell width stay zero.
  always_comb begin
    logic [tgr_pkg::PIXEL_W-1:0] px;
    pixels = '0;
    for (int col = 0; col < tgr_pkg::ROW_SLOTS; col++) begin
      px = '0;
      if (col < int'(width)) begin
        if (col < FONT_COLUMNS && bits[tgr_pkg::ROW_SLOTS-1-col]) begin
          px = text_color;
        end else begin
          px = background_color;
        end
      end
      pixels[tgr_pkg::ROW_W-1-tgr_pkg::PIXEL_W*col -: tgr_pkg::PIXEL_W] = px;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/text_glyph_renderer.sv =====
// Text glyph renderer: cursor, font store and cell sequencer.
// Depends on tgr_pkg, tgr_ram, tgr_row_unit and assert_macros.svh.
//
// Usage: the item channel (item_valid, item_stall, item) carries commands.
// A load command writes one 16-bit font row into the glyph store and gives
// no word. Newline and return only move the cursor. Any other character
// gives a window word (cell rectangle plus panel offsets) followed by one
// pixel row word per cell line, the final one marked with last. Words leave
// on the result channel (result_valid, result_stall, result) from an output
// register. The config channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// is always ready and must be written only while the block is idle.
// Sequence: a drawn character is accepted, gives the window word, then gives
// h row words (h = effective cell height), one a cycle while the receiver
// does not stall, from the row expander fed by the font memory's read port.
// Load, newline and return leave it idle. item_stall is high while a character
// is being drawn. When the receiver stalls, the output word holds and the
// sequencer waits. Reset clears the cursor and restores register defaults;
// font contents are undefined until loaded.
`default_nettype none
`include "assert_macros.svh"

module text_glyph_renderer #(
  parameter int GLYPH_COUNT     = 96,
  parameter int FONT_ROWS       = 16,
  parameter int FONT_COLUMNS    = 12,
  parameter int MAX_CELL_HEIGHT = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  tgr_pkg::item_t                     item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output tgr_pkg::result_t                   result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tgr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [tgr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int STORE_DEPTH = GLYPH_COUNT * FONT_ROWS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int GLYPH_W     = $clog2(GLYPH_COUNT);
  localparam logic [5:0] ROWS_H = 6'(FONT_ROWS);
  localparam logic [5:0] MAX_H  = 6'(MAX_CELL_HEIGHT);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WIN  = 2'd1;
  localparam logic [1:0] ST_ROW  = 2'd2;

  // Configuration registers.
  logic [15:0] text_color;
  logic [15:0] background_color;
  logic [4:0]  cell_width;
  logic [5:0]  cell_height;
  logic [9:0]  indent_column;
  logic [9:0]  screen_width;
  logic [7:0]  panel_x_offset;
  logic [7:0]  panel_y_offset;

  logic [1:0]  state;
  logic [9:0]  cursor_x;
  logic [9:0]  cursor_y;
  logic [5:0]  row;
  logic [GLYPH_W-1:0] glyph;
  logic        glyph_ok;
  logic [10:0] win_x_start;
  logic [10:0] win_x_end;
  logic [10:0] win_y_start;
  logic [10:0] win_y_end;

  logic [4:0]  width_eff;
  logic [5:0]  height_eff;
  logic        item_accept;
  logic        is_load;
  logic        is_newline;
  logic        is_return;
  logic        draw_cmd;
  logic        printable;
  logic [7:0]  glyph_num;
  logic        glyph_in_store;
  logic        load_in_range;
  logic        out_free;
  logic        out_load;
  logic        row_last;
  logic [5:0]  row_sel;
  logic [5:0]  rd_row;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [15:0] rdata;
  logic [15:0] row_bits;
  logic [tgr_pkg::ROW_W-1:0] pixel_row;
  logic [10:0] x_step;
  logic [11:0] x_reach;
  logic        wrap;
  logic [10:0] y_step;
  logic [9:0]  y_down;
  logic [10:0] x_start_calc;
  logic [10:0] y_start_calc;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != ST_IDLE);
  assign item_accept = item_valid && !item_stall;

  assign width_eff = (cell_width < tgr_pkg::WIDTH_MIN) ? tgr_pkg::WIDTH_MIN :
                     (cell_width > tgr_pkg::WIDTH_MAX) ? tgr_pkg::WIDTH_MAX : cell_width;
  assign height_eff = (cell_height < ROWS_H) ? ROWS_H :
                      (cell_height > MAX_H) ? MAX_H : cell_height;

  assign is_load    = (item.command == tgr_pkg::CMD_LOAD);
  assign is_newline = (item.char_code == tgr_pkg::CHAR_NEWLINE);
  assign is_return  = (item.char_code == tgr_pkg::CHAR_RETURN);
  assign draw_cmd   = !is_load && !is_newline && !is_return;
  assign printable  = (item.char_code >= tgr_pkg::FIRST_PRINTABLE) &&
                      (item.char_code <= tgr_pkg::LAST_PRINTABLE);
  assign glyph_num  = item.char_code - tgr_pkg::FIRST_PRINTABLE;
  assign glyph_in_store = printable && (9'(glyph_num) < 9'(GLYPH_COUNT));
  assign load_in_range  = (9'(item.load_glyph) < 9'(GLYPH_COUNT)) &&
                          (6'(item.load_row) < ROWS_H);

  // Cursor advance and window corners, all from the cursor before the move.
  assign x_step  = {1'b0, cursor_x} + {6'b0, width_eff};
  assign x_reach = {1'b0, x_step} + 12'(FONT_COLUMNS);
  assign wrap    = !(x_reach < {2'b0, screen_width});
  assign y_step  = {1'b0, cursor_y} + {5'b0, height_eff};
  assign y_down  = (y_step > {1'b0, tgr_pkg::Y_LIMIT}) ? tgr_pkg::Y_LIMIT : y_step[9:0];
  assign x_start_calc = {1'b0, cursor_x} + {3'b0, panel_x_offset};
  assign y_start_calc = {1'b0, cursor_y} + {3'b0, panel_y_offset};

  assign out_free = !result_valid || !result_stall;
  assign out_load = out_free && ((state == ST_WIN) || (state == ST_ROW));
  assign row_last = ((row + 6'd1) == height_eff);

  // The read address runs one row ahead whenever a row word is taken, so
  // the registered read data always matches the row counter.
  assign row_sel = (state == ST_ROW && out_free) ? row + 6'd1 : row;
  assign rd_row  = (row_sel < ROWS_H) ? row_sel : '0;
  assign raddr   = ADDR_W'(int'(glyph) * FONT_ROWS + int'(rd_row));
  assign waddr   = ADDR_W'(int'(item.load_glyph) * FONT_ROWS + int'(item.load_row));

  assign row_bits = (glyph_ok && row < ROWS_H) ? rdata : '0;

  tgr_ram #(
    .WIDTH (16),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (item_accept && is_load && load_in_range),
    .waddr (waddr),
    .wdata (item.load_bits),
    .raddr (raddr),
    .rdata (rdata)
  );

  tgr_row_unit #(
    .FONT_COLUMNS (FONT_COLUMNS)
  ) u_row (
    .bits             (row_bits),
    .text_color       (text_color),
    .background_color (background_color),
    .width            (width_eff),
    .pixels           (pixel_row)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color       <= tgr_pkg::TEXT_COLOR_RESET;
      background_color <= tgr_pkg::BACKGROUND_RESET;
      cell_width       <= tgr_pkg::CELL_WIDTH_RESET;
      cell_height      <= tgr_pkg::CELL_HEIGHT_RESET;
      indent_column    <= tgr_pkg::INDENT_RESET;
      screen_width     <= tgr_pkg::SCREEN_WIDTH_RESET;
      panel_x_offset   <= tgr_pkg::PANEL_X_RESET;
      panel_y_offset   <= tgr_pkg::PANEL_Y_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tgr_pkg::REG_TEXT_COLOR:     text_color       <= cfg_data;
        tgr_pkg::REG_BACKGROUND:     background_color <= cfg_data;
        tgr_pkg::REG_CELL_WIDTH:     cell_width       <= cfg_data[4:0];
        tgr_pkg::REG_CELL_HEIGHT:    cell_height      <= cfg_data[5:0];
        tgr_pkg::REG_INDENT_COLUMN:  indent_column    <= cfg_data[9:0];
        tgr_pkg::REG_SCREEN_WIDTH:   screen_width     <= cfg_data[9:0];
        tgr_pkg::REG_PANEL_X_OFFSET: panel_x_offset   <= cfg_data[7:0];
        tgr_pkg::REG_PANEL_Y_OFFSET: panel_y_offset   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cursor_x     <= '0;
      cursor_y     <= '0;
      row          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_accept && !is_load) begin
            if (draw_cmd) begin
              state <= ST_WIN;
              row   <= '0;
              if (wrap) begin
                cursor_x <= indent_column;
                cursor_y <= y_down;
              end else begin
                cursor_x <= x_step[9:0];
              end
            end else if (is_newline) begin
              cursor_x <= indent_column;
              cursor_y <= y_down;
            end else begin
              cursor_x <= indent_column;
            end
          end
        end
        ST_WIN: begin
          if (out_free) begin
            state <= ST_ROW;
          end
        end
        ST_ROW: begin
          if (out_free) begin
            row <= row + 6'd1;
            if (row_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Cell payload captured at accept time.
  always_ff @(posedge clk) begin
    if (item_accept && draw_cmd) begin
      glyph       <= glyph_in_store ? GLYPH_W'(glyph_num) : '0;
      glyph_ok    <= glyph_in_store;
      win_x_start <= x_start_calc;
      win_x_end   <= x_start_calc + {6'b0, width_eff} - 11'd1;
      win_y_start <= y_start_calc;
      win_y_end   <= y_start_calc + {5'b0, height_eff} - 11'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == ST_WIN) begin
        result.kind       <= tgr_pkg::KIND_WINDOW;
        result.x_start    <= win_x_start;
        result.x_end      <= win_x_end;
        result.y_start    <= win_y_start;
        result.y_end      <= win_y_end;
        result.pixels_a   <= '0;
        result.pixels_b   <= '0;
        result.pixels_c   <= '0;
        result.pixels_d   <= '0;
        result.row_pixels <= '0;
        result.last       <= 1'b0;
      end else begin
        result.kind       <= tgr_pkg::KIND_ROW;
        result.x_start    <= '0;
        result.x_end      <= '0;
        result.y_start    <= '0;
        result.y_end      <= '0;
        result.pixels_a   <= pixel_row[255:192];
        result.pixels_b   <= pixel_row[191:128];
        result.pixels_c   <= pixel_row[127:64];
        result.pixels_d   <= pixel_row[63:0];
        result.row_pixels <= width_eff;
        result.last       <= row_last;
      end
    end
  end

  `ASSERT_NEXT(a_draw_enters_window, item_accept && draw_cmd, state == ST_WIN, "drawn character did not start a window word")
  `ASSERT_IMPLIES(a_row_in_cell, state == ST_ROW, row < height_eff, "row counter ran past the cell height")
  `ASSERT_IMPLIES(a_idle_after_last, state == ST_IDLE && result_valid, result.last == 1'b1, "sequencer went idle before the last word")

endmodule

`default_nettype wire

// ===== sim/text_glyph_renderer_tb.sv =====
// Self-checking testbench for text_glyph_renderer: a directed table, then random
// phases over several register settings, with every window and pixel-row word predicted.
// Depends on tgr_pkg and the renderer RTL only.
module text_glyph_renderer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GLYPH_COUNT     = 96;
  localparam int FONT_ROWS       = 16;
  localparam int FONT_COLUMNS    = 12;
  localparam int MAX_CELL_HEIGHT = 32;
  localparam int PHASE_ITEMS     = 54;
  localparam int LAST_GLYPH      = tgr_pkg::LAST_PRINTABLE - tgr_pkg::FIRST_PRINTABLE;

  // Row patterns for the first glyph: full, empty, edge columns and bits past the font.
  localparam logic [15:0] PROBE_ROWS [FONT_ROWS] = '{
    16'hFFFF, 16'h0000, 16'h8000, 16'h0010, 16'h0008, 16'h000F, 16'hF000, 16'hAAAA,
    16'h5555, 16'h0FF0, 16'hC003, 16'h8421, 16'h1248, 16'hFFF0, 16'h7FFE, 16'h0001};

  typedef struct {
    tgr_pkg::item_t   stim;
    bit               typed;
    tgr_pkg::result_t window;
  } step_t;

  logic                            clk          = 1'b0;
  logic                            rst          = 1'b1;
  logic                            item_valid   = 1'b0;
  logic                            item_stall;
  tgr_pkg::item_t                  item         = '0;
  logic                            result_valid;
  logic                            result_stall = 1'b0;
  tgr_pkg::result_t                result;
  logic                            cfg_valid    = 1'b0;
  logic                            cfg_ready;
  logic [tgr_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
  logic [tgr_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;

  logic [15:0] fg_color, bg_color;
  logic [4:0]  cell_w;
  logic [5:0]  cell_h;
  logic [9:0]  indent_x, screen_w;
  logic [7:0]  offset_x, offset_y;
  int          cur_x, cur_y;
  logic [15:0] font_rows [GLYPH_COUNT*FONT_ROWS];
  logic [15:0] row_loaded [GLYPH_COUNT];

  tgr_pkg::result_t pending_words [$];
  step_t            script [$];
  tgr_pkg::result_t want_word;
  int      send_idle_pct  = 0;
  int      stall_pct      = 0;
  int      mismatch_count = 0;
  int      words_checked  = 0;
  bit      need_last_glyph = 1'b1;

  text_glyph_renderer dut (.*);

  always #2 clk = ~clk;

  always @(negedge clk) result_stall <= ($urandom_range(0, 99) < stall_pct);

  function automatic int eff_width();
    if (cell_w < tgr_pkg::WIDTH_MIN) return tgr_pkg::WIDTH_MIN;
    if (cell_w > tgr_pkg::WIDTH_MAX) return tgr_pkg::WIDTH_MAX;
    return cell_w;
  endfunction

  function automatic int eff_height();
    if (cell_h < FONT_ROWS) return FONT_ROWS;
    if (cell_h > MAX_CELL_HEIGHT) return MAX_CELL_HEIGHT;
    return cell_h;
  endfunction

  function automatic void line_down();
    int ny;
    ny = cur_y + eff_height();
    cur_y = (ny > tgr_pkg::Y_LIMIT) ? tgr_pkg::Y_LIMIT : ny;
  endfunction

  function automatic void step_cursor();
    int nx;
    nx = cur_x + eff_width();
    if (nx + FONT_COLUMNS < screen_w) begin
      cur_x = nx;
    end else begin
      cur_x = indent_x;
      line_down();
    end
  endfunction

  // Queues the window word and one pixel-row word per cell line.
  function automatic void draw_cell(int glyph, bit use_font);
    int                        w, h;
    logic [15:0]               bits;
    logic [tgr_pkg::ROW_W-1:0] line;
    tgr_pkg::result_t          word;
    w = eff_width();
    h = eff_height();
    word = '0;
    word.kind    = tgr_pkg::KIND_WINDOW;
    word.x_start = 11'(cur_x + offset_x);
    word.x_end   = 11'(cur_x + w - 1 + offset_x);
    word.y_start = 11'(cur_y + offset_y);
    word.y_end   = 11'(cur_y + h - 1 + offset_y);
    pending_words.push_back(word);
    for (int row = 0; row < h; row++) begin
      bits = (use_font && row < FONT_ROWS) ? font_rows[glyph * FONT_ROWS + row] : 16'h0000;
      line = '0;
      for (int col = 0; col < w; col++)
        line[tgr_pkg::ROW_W - 1 - tgr_pkg::PIXEL_W * col -: tgr_pkg::PIXEL_W] =
            (col < FONT_COLUMNS && bits[15 - col]) ? fg_color : bg_color;
      word = '0;
      word.kind = tgr_pkg::KIND_ROW;
      {word.pixels_a, word.pixels_b, word.pixels_c, word.pixels_d} = line;
      word.row_pixels = 5'(w);
      word.last = (row == h - 1);
      pending_words.push_back(word);
    end
  endfunction

  function automatic void render_char(tgr_pkg::item_t it);
    logic [7:0] code;
    code = it.char_code;
    if (it.command == tgr_pkg::CMD_LOAD) begin
      if (it.load_glyph < GLYPH_COUNT) begin
        font_rows[it.load_glyph * FONT_ROWS + it.load_row] = it.load_bits;
        row_loaded[it.load_glyph][it.load_row] = 1'b1;
      end
    end else if (code >= tgr_pkg::FIRST_PRINTABLE && code <= tgr_pkg::LAST_PRINTABLE) begin
      draw_cell(code - tgr_pkg::FIRST_PRINTABLE,
                (code - tgr_pkg::FIRST_PRINTABLE) < GLYPH_COUNT);
      step_cursor();
    end else if (code == tgr_pkg::CHAR_NEWLINE) begin
      cur_x = indent_x;
      line_down();
    end else if (code == tgr_pkg::CHAR_RETURN) begin
      cur_x = indent_x;
    end else begin
      draw_cell(0, 1'b0);
      step_cursor();
    end
  endfunction

  function automatic void apply_reg(logic [tgr_pkg::CFG_INDEX_W-1:0] idx,
                                    logic [tgr_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      tgr_pkg::REG_TEXT_COLOR:     fg_color = data;
      tgr_pkg::REG_BACKGROUND:     bg_color = data;
      tgr_pkg::REG_CELL_WIDTH:     cell_w   = data[4:0];
      tgr_pkg::REG_CELL_HEIGHT:    cell_h   = data[5:0];
      tgr_pkg::REG_INDENT_COLUMN:  indent_x = data[9:0];
      tgr_pkg::REG_SCREEN_WIDTH:   screen_w = data[9:0];
      tgr_pkg::REG_PANEL_X_OFFSET: offset_x = data[7:0];
      tgr_pkg::REG_PANEL_Y_OFFSET: offset_y = data[7:0];
      default: ;
    endcase
  endfunction

  function automatic tgr_pkg::item_t make_item(logic cmd, logic [7:0] code, logic [6:0] glyph,
                                               logic [3:0] row, logic [15:0] bits);
    tgr_pkg::item_t it;
    it.command    = cmd;
    it.char_code  = code;
    it.load_glyph = glyph;
    it.load_row   = row;
    it.load_bits  = bits;
    return it;
  endfunction

  function automatic tgr_pkg::result_t window_word(int xs, int xe, int ys, int ye);
    tgr_pkg::result_t word;
    word = '0;
    word.kind    = tgr_pkg::KIND_WINDOW;
    word.x_start = 11'(xs);
    word.x_end   = 11'(xe);
    word.y_start = 11'(ys);
    word.y_end   = 11'(ye);
    return word;
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_item(input tgr_pkg::item_t it, input bit typed,
                           input tgr_pkg::result_t win);
    int base;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (item_stall);
    base = pending_words.size();
    render_char(it);
    if (typed) pending_words[base] = win;
    @(negedge clk);
  endtask

  // Bits above the register width carry random junk that the block must drop.
  task automatic write_reg(input logic [tgr_pkg::CFG_INDEX_W-1:0] idx, input int value,
                           input int width);
    logic [tgr_pkg::CFG_DATA_W-1:0] mask, data;
    mask = 16'((1 << width) - 1);
    data = (16'($urandom) & ~mask) | (16'(value) & mask);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic program_regs(input int fg, input int bg, input int w, input int h,
                              input int ind, input int scr, input int ox, input int oy);
    write_reg(tgr_pkg::REG_TEXT_COLOR, fg, 16);
    write_reg(tgr_pkg::REG_BACKGROUND, bg, 16);
    write_reg(tgr_pkg::REG_CELL_WIDTH, w, 5);
    write_reg(tgr_pkg::REG_CELL_HEIGHT, h, 6);
    write_reg(tgr_pkg::REG_INDENT_COLUMN, ind, 10);
    write_reg(tgr_pkg::REG_SCREEN_WIDTH, scr, 10);
    write_reg(tgr_pkg::REG_PANEL_X_OFFSET, ox, 8);
    write_reg(tgr_pkg::REG_PANEL_Y_OFFSET, oy, 8);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly prints of fully loaded glyphs; whole-glyph loads keep the font growing.
  task automatic random_burst(input int count);
    int             sent, pick, g;
    logic [63:0]    noise;
    logic [7:0]     code;
    tgr_pkg::item_t it;
    int             ready [$];
    sent = 0;
    while (sent < count) begin
      pick  = $urandom_range(0, 99);
      noise = {$urandom, $urandom};
      it    = noise[$bits(tgr_pkg::item_t)-1:0];
      ready.delete();
      for (int i = 0; i <= LAST_GLYPH; i++)
        if (row_loaded[i] == 16'hFFFF) ready.push_back(i);
      if (need_last_glyph || (pick < 2 && count - sent >= FONT_ROWS)) begin
        g = need_last_glyph ? LAST_GLYPH : $urandom_range(0, GLYPH_COUNT - 1);
        need_last_glyph = 1'b0;
        for (int r = 0; r < FONT_ROWS; r++) begin
          noise = {$urandom, $urandom};
          it    = noise[$bits(tgr_pkg::item_t)-1:0];
          it.command    = tgr_pkg::CMD_LOAD;
          it.load_glyph = 7'(g);
          it.load_row   = 4'(r);
          send_item(it, 1'b0, '0);
        end
        sent += FONT_ROWS;
      end else if (pick < 15) begin
        it.command = tgr_pkg::CMD_LOAD;
        send_item(it, 1'b0, '0);
        if (it.load_glyph < GLYPH_COUNT) sent++;
      end else if (pick < 65) begin
        it.command   = tgr_pkg::CMD_PRINT;
        it.char_code = 8'(ready[$urandom_range(0, ready.size() - 1)] +
                          tgr_pkg::FIRST_PRINTABLE);
        send_item(it, 1'b0, '0);
        sent++;
      end else if (pick < 88) begin
        do begin
          code = $urandom_range(0, 1) ? 8'($urandom_range(0, 32)) : 8'($urandom_range(128, 255));
        end while (code == tgr_pkg::CHAR_NEWLINE || code == tgr_pkg::CHAR_RETURN);
        it.command   = tgr_pkg::CMD_PRINT;
        it.char_code = code;
        send_item(it, 1'b0, '0);
        sent++;
      end else begin
        it.command   = tgr_pkg::CMD_PRINT;
        it.char_code = pick[0] ? tgr_pkg::CHAR_NEWLINE : tgr_pkg::CHAR_RETURN;
        send_item(it, 1'b0, '0);
        sent++;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("word %0d: %s expected %h, got %h", words_checked, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_words.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("word with nothing expected: %p", result);
      end else begin
        want_word = pending_words.pop_front();
        check_field("kind", want_word.kind, result.kind);
        check_field("x_start", want_word.x_start, result.x_start);
        check_field("x_end", want_word.x_end, result.x_end);
        check_field("y_start", want_word.y_start, result.y_start);
        check_field("y_end", want_word.y_end, result.y_end);
        check_field("pixels_a", want_word.pixels_a, result.pixels_a);
        check_field("pixels_b", want_word.pixels_b, result.pixels_b);
        check_field("pixels_c", want_word.pixels_c, result.pixels_c);
        check_field("pixels_d", want_word.pixels_d, result.pixels_d);
        check_field("row_pixels", want_word.row_pixels, result.row_pixels);
        check_field("last", want_word.last, result.last);
      end
      words_checked++;
    end
  end

  initial begin
    fg_color = tgr_pkg::TEXT_COLOR_RESET;
    bg_color = tgr_pkg::BACKGROUND_RESET;
    cell_w   = tgr_pkg::CELL_WIDTH_RESET;
    cell_h   = tgr_pkg::CELL_HEIGHT_RESET;
    indent_x = tgr_pkg::INDENT_RESET;
    screen_w = tgr_pkg::SCREEN_WIDTH_RESET;
    offset_x = tgr_pkg::PANEL_X_RESET;
    offset_y = tgr_pkg::PANEL_Y_RESET;
    cur_x    = 0;
    cur_y    = 0;
    foreach (row_loaded[i]) row_loaded[i] = '0;

    // Directed table, run at the reset register values.
    script.push_back('{make_item(tgr_pkg::CMD_PRINT, 8'd32, 7'd0, 4'd0, 16'h0000), 1'b1,
                       window_word(40, 51, 53, 68)});
    for (int r = 0; r < FONT_ROWS; r++)
      script.push_back('{make_item(tgr_pkg::CMD_LOAD, 8'($urandom), 7'd0, 4'(r),
                                   PROBE_ROWS[r]),
                         1'b0, '0});
    script.push_back('{make_item(tgr_pkg::CMD_LOAD, 8'd255, 7'd95, 4'd15, 16'hFFFF),
                       1'b0, '0});
    // Loads past the glyph store are dropped.
    script.push_back('{make_item(tgr_pkg::CMD_LOAD, 8'd0, 7'd127, 4'd0, 16'h1234),
                       1'b0, '0});
    script.push_back('{make_item(tgr_pkg::CMD_LOAD, 8'd33, 7'd96, 4'd7, 16'hFFFF),
                       1'b0, '0});
    script.push_back('{make_item(tgr_pkg::CMD_PRINT, 8'd33, 7'd0, 4'd0, 16'h0000), 1'b1,
                       window_word(52, 63, 53, 68)});
    script.push_back('{make_item(tgr_pkg::CMD_PRINT, tgr_pkg::CHAR_NEWLINE, 7'd0, 4'd0,
                                 16'h0000),
                       1'b0, '0});
    script.push_back('{make_item(tgr_pkg::CMD_PRINT, tgr_pkg::CHAR_RETURN, 7'd0, 4'd0,
                                 16'h0000),
                       1'b0, '0});
    script.push_back('{make_item(tgr_pkg::CMD_PRINT, 8'd255, 7'd0, 4'd0, 16'h0000), 1'b1,
                       window_word(40, 51, 69, 84)});
    script.push_back('{make_item(tgr_pkg::CMD_PRINT, 8'd0, 7'd127, 4'd15, 16'hFFFF),
                       1'b0, '0});

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    foreach (script[i]) send_item(script[i].stim, script[i].typed, script[i].window);

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: program_regs(16'hFFFF, 16'h0000, 16, 32, 0, 1023, 255, 255);
        1: program_regs(16'h0000, 16'hFFFF, 1, 16, 0, 16, 0, 0);
        2: program_regs($urandom, $urandom, 0, 0, $urandom_range(0, 200),
                        $urandom_range(16, 1023), $urandom_range(0, 255), $urandom_range(0, 255));
        3: program_regs($urandom, $urandom, 31, 63, $urandom_range(0, 1023),
                        $urandom_range(16, 1023), $urandom_range(0, 255), $urandom_range(0, 255));
        4: program_regs($urandom, $urandom, $urandom_range(0, 31), $urandom_range(0, 63),
                        $urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 255), $urandom_range(0, 255));
        7: program_regs($urandom, $urandom, $urandom_range(4, 16), 32, 1023, 16, 255, 255);
        default: program_regs($urandom, $urandom, $urandom_range(1, 16), $urandom_range(16, 32),
                              $urandom_range(0, 1023), $urandom_range(16, 1023),
                              $urandom_range(0, 255), $urandom_range(0, 255));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 12; stall_pct = 12; end
      endcase
      random_burst(PHASE_ITEMS);
    end

    drain();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== text_glyph_renderer.f =====
+incdir+hdl
hdl/tgr_pkg.sv
hdl/tgr_ram.sv
hdl/tgr_row_unit.sv
hdl/text_glyph_renderer.sv
sim/text_glyph_renderer_tb.sv
